// ===== design/kei_pkg.sv =====
// Package for the keyframe easing interpolator: request and result types,
// codes, widths and the rounding helper. No dependencies.
`default_nettype none
package kei_pkg;

    localparam int TIME_W       = 63;
    localparam int PER_W        = 48;
    localparam int WORD_W       = 32;
    localparam int PROGRESS_ONE = 65536;
    localparam int PROG_BITS    = $clog2(PROGRESS_ONE);
    localparam int PROG_W       = PROG_BITS + 1;
    localparam int VALUE_WORDS  = 8;
    localparam int DELTA_W      = WORD_W + 2;
    localparam int PROD_W       = DELTA_W + PROG_W + 1;

    typedef enum logic [2:0] {
        EASE_LINEAR = 3'd0,
        EASE_IN     = 3'd1,
        EASE_OUT    = 3'd2,
        EASE_IN_OUT = 3'd3
    } easing_t;

    typedef enum logic [1:0] {
        DIR_NORMAL  = 2'd0,
        DIR_REVERSE = 2'd1,
        DIR_ALT     = 2'd2,
        DIR_ALT_REV = 2'd3
    } direction_t;

    typedef enum logic [2:0] {
        PROP_OPACITY  = 3'd0,
        PROP_CORNERS  = 3'd1,
        PROP_SHADOW   = 3'd2,
        PROP_BACKDROP = 3'd3,
        PROP_AFFINE   = 3'd4
    } property_t;

    typedef enum logic [1:0] {
        KIND_UNSIGNED,
        KIND_SIGNED,
        KIND_COLOUR,
        KIND_DISCRETE
    } kind_t;

    localparam logic [2:0] SHADOW_COLOUR_WORD     = 3'd4;
    localparam logic [2:0] BACKDROP_COLOUR_WORD   = 3'd2;
    localparam logic [2:0] BACKDROP_DISCRETE_WORD = 3'd5;
    localparam logic [VALUE_WORDS-1:0] SHADOW_SIGNED_MASK = 8'h03;

    typedef struct packed {
        logic [TIME_W-1:0] now_ns;
        logic [TIME_W-1:0] launch_ns;
        logic [TIME_W-1:0] end_ns;
        logic [PER_W-1:0]  period_ns;
        logic [31:0]       play_count;
        logic [2:0]        easing;
        logic [1:0]        direction;
        logic [2:0]        property_req;
        logic [2:0]        word_index;
        logic [WORD_W-1:0] from_word;
        logic [WORD_W-1:0] to_word;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] value_word;
        logic              terminal;
        logic              status;
    } result_t;

    // Per-request control carried alongside the divider rows
    typedef struct packed {
        logic              rm;
        logic              early;
        logic              ended;
        logic              odd;
        logic [2:0]        easing;
        logic [1:0]        direction;
        logic [2:0]        prop;
        logic [2:0]        widx;
        logic [WORD_W-1:0] from_word;
        logic [WORD_W-1:0] to_word;
    } ctl_t;

    function automatic kind_t word_kind(input logic [2:0] prop, input logic [2:0] widx);
        kind_t k;
        k = KIND_UNSIGNED;
        case (prop)
            PROP_SHADOW:
            begin
                if (widx == SHADOW_COLOUR_WORD)
                    k = KIND_COLOUR;
                else if (SHADOW_SIGNED_MASK[widx])
                    k = KIND_SIGNED;
            end
            PROP_BACKDROP:
            begin
                if (widx == BACKDROP_COLOUR_WORD)
                    k = KIND_COLOUR;
                else if (widx == BACKDROP_DISCRETE_WORD)
                    k = KIND_DISCRETE;
            end
            PROP_AFFINE:    k = KIND_SIGNED;
            default:        k = KIND_UNSIGNED;
        endcase
        return k;
    endfunction

    // Scale by one progress unit, rounding half away from zero, kept mod 2^32
    function automatic logic [WORD_W-1:0] round_scale(input logic signed [PROD_W-1:0] n);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] r;
        m = n[PROD_W-1] ? (PROD_W'(0) - PROD_W'(n)) : PROD_W'(n);
        r = (m + PROD_W'(PROGRESS_ONE / 2)) >> PROG_BITS;
        return n[PROD_W-1] ? (WORD_W'(0) - r[WORD_W-1:0]) : r[WORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/kei_div_cell.sv =====
// One restoring-division cell: one quotient bit per cycle, registered.
// Depends on kei_pkg.
`default_nettype none
module kei_div_cell #(
    parameter int NUMW = 63,
    parameter int SW   = 1
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [kei_pkg::PER_W-1:0] in_rem,
    input  wire logic [NUMW-1:0]          in_num,
    input  wire logic [kei_pkg::PER_W-1:0] in_div,
    input  wire logic [SW-1:0]            in_side,
    output logic                          out_valid,
    output logic [kei_pkg::PER_W-1:0]     out_rem,
    output logic [NUMW-1:0]               out_num,
    output logic [kei_pkg::PER_W-1:0]     out_div,
    output logic [SW-1:0]                 out_side
);
    import kei_pkg::*;

    logic                valid_reg;
    logic [PER_W-1:0]    rem_reg, rem_next;
    logic [NUMW-1:0]     num_reg, num_next;
    logic [PER_W-1:0]    div_reg;
    logic [SW-1:0]       side_reg;
    logic [PER_W:0]      trial;
    logic [PER_W:0]      diff;
    logic                qbit;

    always_comb
    begin
        trial    = {in_rem, in_num[NUMW-1]};
        diff     = trial - {1'b0, in_div};
        qbit     = (trial >= {1'b0, in_div});
        rem_next = qbit ? diff[PER_W-1:0] : trial[PER_W-1:0];
        // shift the quotient bit into the vacated low end
        num_next = {in_num[NUMW-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        div_reg  <= in_div;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

// ===== design/kei_div_chain.sv =====
// Row of NUMW division cells giving quotient and remainder of a NUMW-bit
// dividend with a preloaded partial remainder. Depends on kei_pkg, kei_div_cell.
`default_nettype none
module kei_div_chain #(
    parameter int NUMW = 63,
    parameter int SW   = 1
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [kei_pkg::PER_W-1:0] in_rem,
    input  wire logic [NUMW-1:0]          in_num,
    input  wire logic [kei_pkg::PER_W-1:0] in_div,
    input  wire logic [SW-1:0]            in_side,
    output logic                          out_valid,
    output logic [kei_pkg::PER_W-1:0]     out_rem,
    output logic [NUMW-1:0]               out_num,
    output logic [kei_pkg::PER_W-1:0]     out_div,
    output logic [SW-1:0]                 out_side
);
    import kei_pkg::*;

    logic                valid_w [NUMW+1];
    logic [PER_W-1:0]    rem_w   [NUMW+1];
    logic [NUMW-1:0]     num_w   [NUMW+1];
    logic [PER_W-1:0]    div_w   [NUMW+1];
    logic [SW-1:0]       side_w  [NUMW+1];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = in_rem;
    assign num_w[0]   = in_num;
    assign div_w[0]   = in_div;
    assign side_w[0]  = in_side;

    for (genvar i = 0; i < NUMW; i++)
    begin : g_cell
        kei_div_cell #(.NUMW(NUMW), .SW(SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (valid_w[i]),
            .in_rem   (rem_w[i]),
            .in_num   (num_w[i]),
            .in_div   (div_w[i]),
            .in_side  (side_w[i]),
            .out_valid(valid_w[i+1]),
            .out_rem  (rem_w[i+1]),
            .out_num  (num_w[i+1]),
            .out_div  (div_w[i+1]),
            .out_side (side_w[i+1])
        );
    end

    assign out_valid = valid_w[NUMW];
    assign out_rem   = rem_w[NUMW];
    assign out_num   = num_w[NUMW];
    assign out_div   = div_w[NUMW];
    assign out_side  = side_w[NUMW];

endmodule
`default_nettype wire

// ===== design/kei_blend.sv =====
// Easing, direction and word blending stages after the progress divider.
// Depends on kei_pkg.
`default_nettype none
module kei_blend (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [kei_pkg::PROG_W-1:0] in_prog,
    input  wire kei_pkg::ctl_t             in_ctl,
    output logic                           done,
    output kei_pkg::result_t               result
);
    import kei_pkg::*;

    localparam logic [PROG_W-1:0] ONE  = PROG_W'(PROGRESS_ONE);
    localparam int SQ_W = 2 * PROG_W;

    // square stage
    logic              d_valid_reg;
    logic [PROG_W-1:0] d_prog_reg;
    logic              d_half_reg;
    logic [SQ_W-1:0]   d_sq_reg;
    ctl_t              d_ctl_reg;
    logic [PROG_W-1:0] inv;
    logic              half;
    logic [PROG_W-1:0] sq_op;

    // easing stage
    logic              e_valid_reg;
    logic [PROG_W-1:0] e_eased_reg, e_eased_next;
    ctl_t              e_ctl_reg;
    logic [SQ_W+1:0]   t_wide;
    logic [PROG_W-1:0] t;
    logic [PROG_W-1:0] eased;
    logic              forward;

    // multiply stage
    logic                    f_valid_reg;
    logic [PROG_W-1:0]       f_eased_reg;
    ctl_t                    f_ctl_reg;
    kind_t                   f_kind_reg, kind;
    logic signed [PROD_W-1:0] f_prod_reg;
    logic signed [26:0]      f_bprod_reg [4];
    logic signed [DELTA_W-1:0] a_s, b_s, delta;

    // output stage
    logic              done_reg;
    result_t           result_reg, result_next;
    logic [WORD_W-1:0] word_val;
    logic [WORD_W-1:0] byte_scaled;

    always_comb
    begin
        inv   = ONE - in_prog;
        half  = ({1'b0, in_prog} << 1) <= {1'b0, ONE};
        sq_op = ((in_ctl.easing == EASE_IN) || ((in_ctl.easing == EASE_IN_OUT) && half))
                ? in_prog : inv;
    end

    always_ff @(posedge clk)
    begin
        d_prog_reg <= in_prog;
        d_half_reg <= half;
        d_sq_reg   <= sq_op * sq_op;
        d_ctl_reg  <= in_ctl;
    end

    always_comb
    begin
        if (d_ctl_reg.easing == EASE_IN_OUT)
            t_wide = {1'b0, d_sq_reg, 1'b0};
        else
            t_wide = {2'b00, d_sq_reg};
        t_wide = (t_wide + (SQ_W+2)'(PROGRESS_ONE / 2)) >> PROG_BITS;
        t      = t_wide[PROG_W-1:0];
        case (d_ctl_reg.easing)
            EASE_IN:     eased = t;
            EASE_OUT:    eased = ONE - t;
            EASE_IN_OUT: eased = d_half_reg ? t : ONE - t;
            default:     eased = d_prog_reg;
        endcase
        case (d_ctl_reg.direction)
            DIR_NORMAL:  forward = 1'b1;
            DIR_REVERSE: forward = 1'b0;
            DIR_ALT:     forward = !d_ctl_reg.odd;
            default:     forward = d_ctl_reg.odd;
        endcase
        e_eased_next = forward ? eased : ONE - eased;
    end

    always_ff @(posedge clk)
    begin
        e_eased_reg <= e_eased_next;
        e_ctl_reg   <= d_ctl_reg;
    end

    always_comb
    begin
        kind = word_kind(e_ctl_reg.prop, e_ctl_reg.widx);
        if (kind == KIND_SIGNED)
        begin
            a_s = DELTA_W'($signed(e_ctl_reg.from_word));
            b_s = DELTA_W'($signed(e_ctl_reg.to_word));
        end
        else
        begin
            a_s = DELTA_W'({1'b0, e_ctl_reg.from_word});
            b_s = DELTA_W'({1'b0, e_ctl_reg.to_word});
        end
        delta = b_s - a_s;
    end

    always_ff @(posedge clk)
    begin
        f_eased_reg <= e_eased_reg;
        f_ctl_reg   <= e_ctl_reg;
        f_kind_reg  <= kind;
        f_prod_reg  <= PROD_W'(delta * $signed({1'b0, e_eased_reg}));
        for (int k = 0; k < 4; k++)
        begin
            f_bprod_reg[k] <= 27'(($signed({1'b0, e_ctl_reg.to_word[8*k +: 8]})
                                   - $signed({1'b0, e_ctl_reg.from_word[8*k +: 8]}))
                                  * $signed({1'b0, e_eased_reg}));
        end
    end

    always_comb
    begin
        word_val    = 32'd0;
        byte_scaled = '0;
        case (f_kind_reg)
            KIND_DISCRETE:
                word_val = (f_eased_reg < ONE) ? f_ctl_reg.from_word : f_ctl_reg.to_word;
            KIND_COLOUR:
                for (int k = 0; k < 4; k++)
                begin
                    byte_scaled = round_scale(PROD_W'(f_bprod_reg[k]));
                    word_val[8*k +: 8] = f_ctl_reg.from_word[8*k +: 8] + byte_scaled[7:0];
                end
            default:
                word_val = f_ctl_reg.from_word + round_scale(f_prod_reg);
        endcase

        result_next = '0;
        if (f_ctl_reg.rm)
        begin
            result_next.value_word = f_ctl_reg.to_word;
            result_next.terminal   = 1'b1;
        end
        else if (f_ctl_reg.early)
            result_next.value_word = f_ctl_reg.from_word;
        else if ((f_ctl_reg.prop > PROP_AFFINE) || (f_ctl_reg.easing > EASE_IN_OUT))
            result_next.status = 1'b1;
        else
        begin
            result_next.value_word = word_val;
            result_next.terminal   = f_ctl_reg.ended;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            d_valid_reg <= in_valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            done_reg    <= f_valid_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== design/keyframe_easing_interpolator.sv =====
// Top level of the keyframe easing interpolator: request register, two
// division rows and the blend stages. Depends on kei_pkg, kei_div_chain, kei_blend.
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+--------------------------------
//  request   | start, busy, item          | taken when start && !busy
//  result    | done, result               | one-cycle strobe, no back-pressure
//  config    | cfg_we, cfg_data           | written when cfg_we is high
//
// One request per clock; each result is strobed once its request has passed
// the 63-cell row for play number and phase, the 17-cell row for rounded
// progress, and the request, square, easing, multiply and output registers.
// busy stays low; results never stall.
// Reset clears reduced motion and all valid flags.
`default_nettype none
module keyframe_easing_interpolator (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire kei_pkg::item_t   item,
    output logic                  done,
    output kei_pkg::result_t      result,
    input  wire logic             cfg_we,
    input  wire logic             cfg_data
);
    import kei_pkg::*;

    localparam int CTL_W = $bits(ctl_t);

    logic              rm_reg;
    logic              a_valid_reg;
    item_t             a_item_reg;
    logic              a_rm_reg;

    logic [TIME_W-1:0] elapsed;
    logic [PER_W-1:0]  per;
    ctl_t              b_ctl;

    logic              c1_valid;
    logic [PER_W-1:0]  c1_rem;
    logic [TIME_W-1:0] c1_num;
    logic [PER_W-1:0]  c1_div;
    logic [CTL_W-1:0]  c1_side;
    ctl_t              c1_ctl, c_ctl;
    logic [PER_W-1:0]  phase;
    logic [PER_W+PROG_BITS:0] numer;

    logic              c2_valid;
    logic [PER_W-1:0]  c2_rem;
    logic [PROG_W-1:0] c2_num;
    logic [PER_W-1:0]  c2_div;
    logic [CTL_W-1:0]  c2_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rm_reg      <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rm_reg <= cfg_data;
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_item_reg <= item;
        a_rm_reg   <= rm_reg;
    end

    always_comb
    begin
        elapsed         = a_item_reg.now_ns - a_item_reg.launch_ns;
        per             = (a_item_reg.period_ns == '0) ? PER_W'(1) : a_item_reg.period_ns;
        b_ctl.rm        = a_rm_reg;
        b_ctl.early     = a_item_reg.now_ns < a_item_reg.launch_ns;
        b_ctl.ended     = a_item_reg.now_ns >= a_item_reg.end_ns;
        // parity of play_count - 1, used once the end is reached
        b_ctl.odd       = !a_item_reg.play_count[0];
        b_ctl.easing    = a_item_reg.easing;
        b_ctl.direction = a_item_reg.direction;
        b_ctl.prop      = a_item_reg.property_req;
        b_ctl.widx      = a_item_reg.word_index;
        b_ctl.from_word = a_item_reg.from_word;
        b_ctl.to_word   = a_item_reg.to_word;
    end

    kei_div_chain #(.NUMW(TIME_W), .SW(CTL_W)) u_play_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (a_valid_reg),
        .in_rem   ('0),
        .in_num   (elapsed),
        .in_div   (per),
        .in_side  (b_ctl),
        .out_valid(c1_valid),
        .out_rem  (c1_rem),
        .out_num  (c1_num),
        .out_div  (c1_div),
        .out_side (c1_side)
    );

    always_comb
    begin
        c1_ctl = ctl_t'(c1_side);
        c_ctl  = c1_ctl;
        if (!c1_ctl.ended)
            c_ctl.odd = c1_num[0];
        // at or past the end the phase is a whole period
        phase = c1_ctl.ended ? c1_div : c1_rem;
        numer = {1'b0, phase, PROG_BITS'(0)} + (PER_W+PROG_BITS+1)'(c1_div[PER_W-1:1]);
    end

    kei_div_chain #(.NUMW(PROG_W), .SW(CTL_W)) u_prog_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c1_valid),
        .in_rem   (numer[PER_W+PROG_BITS:PROG_W]),
        .in_num   (numer[PROG_W-1:0]),
        .in_div   (c1_div),
        .in_side  (c_ctl),
        .out_valid(c2_valid),
        .out_rem  (c2_rem),
        .out_num  (c2_num),
        .out_div  (c2_div),
        .out_side (c2_side)
    );

    kei_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(c2_valid),
        .in_prog (c2_num),
        .in_ctl  (ctl_t'(c2_side)),
        .done    (done),
        .result  (result)
    );

    // remainder and divisor of the progress row are not needed past it
    logic unused_ok;
    assign unused_ok = ^{c2_rem, c2_div};

    assign busy = 1'b0 & unused_ok;

endmodule
`default_nettype wire
